@@ src/scd_pkg.sv @@
// Shared types, constants and the sine table builder for the stereo chorus delay.
`timescale 1ns / 1ps
package scd_pkg;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WRITE,
        S_ROM,
        S_MOD,
        S_POS,
        S_RDA,
        S_RDB,
        S_INT1,
        S_INT2,
        S_MIX1,
        S_MIX2,
        S_MIX3,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        REG_LFO_STEP   = 2'd0,
        REG_MOD_DEPTH  = 2'd1,
        REG_BASE_DELAY = 2'd2,
        REG_WET_MIX    = 2'd3
    } reg_idx_t;

    // controller -> datapath
    typedef struct packed {
        logic clr_en;
        logic capture;
        logic wr_en;
        logic rom_en;
        logic mod_en;
        logic pos_en;
        logic rdb_en;
        logic int1_en;
        logic int2_en;
        logic mix1_en;
        logic mix2_en;
        logic mix3_en;
        logic out_load;
        logic commit;
        logic ch;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic out_free;
    } dp_sts_t;

    localparam logic [31:0] LFO_STEP_RST   = 32'd65840;
    localparam logic [16:0] MOD_DEPTH_RST  = 17'd17710;
    localparam logic [19:0] BASE_DELAY_RST = 20'd149424;
    localparam logic [16:0] WET_MIX_RST    = 17'd32896;

    localparam logic [16:0] WET_FULL      = 17'd65536;
    localparam logic [31:0] QUARTER_PHASE = 32'h4000_0000;
    localparam logic [16:0] ONE_SAMPLE    = 17'd65536;
    localparam logic [15:0] ROUND_HALF    = 16'd32768;

    // Q30 product, truncated toward zero
    function automatic longint mul_q30(input longint a, input longint b);
        longint p;
        p = a * b;
        if (p >= 0)
            return p >>> 30;
        return -((-p) >>> 30);
    endfunction

    // 9th-order odd sine polynomial, x in Q30 of a quarter turn, result Q16 clamped
    function automatic int sine_poly(input longint x);
        longint x2;
        longint acc;
        longint v;
        x2  = mul_q30(x, x);
        acc = 64'sd172272;
        acc = -64'sd5026995 + mul_q30(acc, x2);
        acc = 64'sd85569306 + mul_q30(acc, x2);
        acc = -64'sd693598668 + mul_q30(acc, x2);
        acc = 64'sd1686629713 + mul_q30(acc, x2);
        acc = mul_q30(acc, x);
        v   = (acc + 64'sd8192) >>> 14;
        if (v < 0)
            v = 0;
        if (v > 65536)
            v = 65536;
        return int'(v);
    endfunction

endpackage

@@ src/stereo_chorus_delay_unit.sv @@
// Top level of the stereo chorus delay: APB registers, controller and datapath.
// Sequence: an accepted item passes one write step, ten steps a channel and
//   one output load, which waits while a stalled result is still held.
// Items are taken one at a time, the next only after the last result loads;
//   both channels share one read address on the delay lines.
// Reset: registers take their defaults, then a clearing pass over all
//   LINE_DEPTH entries zeroes both delay lines before the first item is taken.
`timescale 1ns / 1ps
module stereo_chorus_delay_unit #(
    parameter int LINE_DEPTH      = 8192,
    parameter int SAMPLE_BITS     = 24,
    parameter int SINE_TABLE_SIZE = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input items
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] left_in,
    input  logic signed [SAMPLE_BITS-1:0] right_in,
    // result items
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] left_out,
    output logic signed [SAMPLE_BITS-1:0] right_out,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import scd_pkg::*;

    // Line depth and sine table size must be powers of two (the block does not check
    // this): tap wrap is a mask and the table index is the top bits of the phase.

    logic [31:0] lfo_step_reg;
    logic [16:0] mod_depth_reg;
    logic [19:0] base_delay_reg;
    logic [16:0] wet_mix_reg;
    logic        wr_hit;
    reg_idx_t    reg_sel;

    assign pready  = 1'b1;
    assign wr_hit  = psel && penable && pwrite && pready;
    assign reg_sel = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfo_step_reg   <= LFO_STEP_RST;
            mod_depth_reg  <= MOD_DEPTH_RST;
            base_delay_reg <= BASE_DELAY_RST;
            wet_mix_reg    <= WET_MIX_RST;
        end
        else if (wr_hit)
        begin
            unique case (reg_sel)
                REG_LFO_STEP:   lfo_step_reg   <= pwdata;
                REG_MOD_DEPTH:  mod_depth_reg  <= pwdata[16:0];
                REG_BASE_DELAY: base_delay_reg <= pwdata[19:0];
                REG_WET_MIX:    wet_mix_reg    <= pwdata[16:0];
                default:        lfo_step_reg   <= lfo_step_reg;
            endcase
        end
    end

    // readback
    always_comb
    begin
        unique case (reg_sel)
            REG_LFO_STEP:   prdata = lfo_step_reg;
            REG_MOD_DEPTH:  prdata = 32'(mod_depth_reg);
            REG_BASE_DELAY: prdata = 32'(base_delay_reg);
            REG_WET_MIX:    prdata = 32'(wet_mix_reg);
            default:        prdata = '0;
        endcase
    end

    dp_cmd_t cmd;
    dp_sts_t sts;

    // one item at a time; in_stall drops only while idle
    scd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .sts      (sts)
    );

    // write both lines, then per channel: sine lookup, modulation, tap
    // position, two line reads, interpolation and dry/wet mix
    scd_dpath #(
        .LINE_DEPTH      (LINE_DEPTH),
        .SAMPLE_BITS     (SAMPLE_BITS),
        .SINE_TABLE_SIZE (SINE_TABLE_SIZE)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .left_in    (left_in),
        .right_in   (right_in),
        .lfo_step   (lfo_step_reg),
        .mod_depth  (mod_depth_reg),
        .base_delay (base_delay_reg),
        .wet_mix    (wet_mix_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .left_out   (left_out),
        .right_out  (right_out)
    );

endmodule

@@ src/scd_ctrl.sv @@
// Sequencing state machine for the stereo chorus delay.
`timescale 1ns / 1ps
module scd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output scd_pkg::dp_cmd_t cmd,
    input  scd_pkg::dp_sts_t sts
);
    import scd_pkg::*;

    state_t state_reg, state_next;
    logic   ch_reg, ch_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ch_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        unique case (state_reg)
            S_CLEAR: if (sts.clr_last) state_next = S_IDLE;
            S_IDLE:  if (in_valid) state_next = S_WRITE;
            S_WRITE:
            begin
                ch_next    = 1'b0;
                state_next = S_ROM;
            end
            S_ROM:  state_next = S_MOD;
            S_MOD:  state_next = S_POS;
            S_POS:  state_next = S_RDA;
            S_RDA:  state_next = S_RDB;
            S_RDB:  state_next = S_INT1;
            S_INT1: state_next = S_INT2;
            S_INT2: state_next = S_MIX1;
            S_MIX1: state_next = S_MIX2;
            S_MIX2: state_next = S_MIX3;
            S_MIX3:
            begin
                if (ch_reg)
                    state_next = S_DONE;
                else
                begin
                    ch_next    = 1'b1;
                    state_next = S_ROM;
                end
            end
            S_DONE: if (sts.out_free) state_next = S_IDLE;
            default: state_next = S_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.ch   = ch_reg;
        in_stall = (state_reg != S_IDLE);
        unique case (state_reg)
            S_CLEAR: cmd.clr_en  = 1'b1;
            S_IDLE:  cmd.capture = in_valid;
            S_WRITE: cmd.wr_en   = 1'b1;
            S_ROM:   cmd.rom_en  = 1'b1;
            S_MOD:   cmd.mod_en  = 1'b1;
            S_POS:   cmd.pos_en  = 1'b1;
            S_RDA:   cmd.ch      = ch_reg;
            S_RDB:   cmd.rdb_en  = 1'b1;
            S_INT1:  cmd.int1_en = 1'b1;
            S_INT2:  cmd.int2_en = 1'b1;
            S_MIX1:  cmd.mix1_en = 1'b1;
            S_MIX2:  cmd.mix2_en = 1'b1;
            S_MIX3:  cmd.mix3_en = 1'b1;
            S_DONE:
            begin
                cmd.out_load = sts.out_free;
                cmd.commit   = sts.out_free;
            end
            default: cmd.clr_en = 1'b0;
        endcase
    end

    a_no_reclear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_CLEAR |=> state_reg != S_CLEAR)
        else $error("clearing pass restarted");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over a waiting result");
    a_capture_write: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == S_WRITE)
        else $error("captured item not written");

endmodule

@@ src/scd_dpath.sv @@
// Delay lines, sine table, tap arithmetic and output register of the chorus.
`timescale 1ns / 1ps
module scd_dpath #(
    parameter int LINE_DEPTH      = 8192,
    parameter int SAMPLE_BITS     = 24,
    parameter int SINE_TABLE_SIZE = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  scd_pkg::dp_cmd_t              cmd,
    output scd_pkg::dp_sts_t              sts,
    input  logic signed [SAMPLE_BITS-1:0] left_in,
    input  logic signed [SAMPLE_BITS-1:0] right_in,
    input  logic [31:0]                   lfo_step,
    input  logic [16:0]                   mod_depth,
    input  logic [19:0]                   base_delay,
    input  logic [16:0]                   wet_mix,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] left_out,
    output logic signed [SAMPLE_BITS-1:0] right_out
);
    import scd_pkg::*;

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int PF = AW + 16;
    localparam int SB = $clog2(SINE_TABLE_SIZE);
    localparam int QL = SINE_TABLE_SIZE / 4;
    localparam int RA = SB - 1;
    localparam int SW = SAMPLE_BITS;

    // quarter-wave sine table, Q16
    logic [16:0] sine_tab [QL+1];
    for (genvar k = 0; k <= QL; k++)
    begin : g_sine
        localparam longint XK = (longint'(k) * (64'sd1 <<< 30)) / QL;
        assign sine_tab[k] = 17'(sine_poly(XK));
    end

    logic [AW-1:0]   clr_cnt_reg;
    logic [AW-1:0]   widx_reg;
    logic [31:0]     phase_reg;
    logic            out_valid_reg;
    logic signed [SW-1:0] lin_reg, rin_reg;
    logic [16:0]     rom_q;
    logic            neg_reg;
    logic signed [26:0] mod_reg;
    logic [PF-1:0]   pos_reg;
    logic signed [SW-1:0] a_reg, wet_reg, lres_reg, rres_reg, lout_reg, rout_reg;
    logic signed [SW+17:0] prod_reg, p1_reg, p2_reg;
    logic signed [SW-1:0] rdl_q, rdr_q;
    logic signed [SW-1:0] lmem [LINE_DEPTH];
    logic signed [SW-1:0] rmem [LINE_DEPTH];

    // memory port
    logic            mem_we;
    logic [AW-1:0]   waddr, raddr, i0;
    logic signed [SW-1:0] wl_data, wr_data;

    assign i0      = pos_reg[PF-1:16];
    assign mem_we  = cmd.clr_en || cmd.wr_en;
    assign waddr   = cmd.clr_en ? clr_cnt_reg : widx_reg;
    assign wl_data = cmd.clr_en ? '0 : lin_reg;
    assign wr_data = cmd.clr_en ? '0 : rin_reg;
    assign raddr   = cmd.rdb_en ? i0 + AW'(1) : i0;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            lmem[waddr] <= wl_data;
            rmem[waddr] <= wr_data;
        end
        rdl_q <= lmem[raddr];
        rdr_q <= rmem[raddr];
    end

    // sine table address from phase
    logic [31:0]   ph;
    logic [SB-1:0] sidx;
    logic [SB-3:0] srem;
    logic [RA-1:0] rom_addr;
    assign ph       = cmd.ch ? phase_reg + QUARTER_PHASE : phase_reg;
    assign sidx     = ph[31 -: SB];
    assign srem     = sidx[SB-3:0];
    assign rom_addr = sidx[SB-2] ? RA'(QL) - RA'(srem) : RA'(srem);

    // arithmetic
    logic signed [17:0]   sine_s;
    logic signed [35:0]   mprod;
    logic [PF-1:0]        pos_next;
    logic signed [SW-1:0] rd_sel, dry_sel;
    logic signed [SW:0]   diff;
    logic [16:0]          m_sat;
    logic signed [SW+18:0] sum;
    logic signed [SW+2:0]  mixv;
    logic signed [SW-1:0]  mix_sat;

    localparam logic signed [SW+2:0] SAT_HI = (SW+3)'((64'sd1 <<< (SW-1)) - 1);
    localparam logic signed [SW+2:0] SAT_LO = -SAT_HI - (SW+3)'(1);

    assign sine_s  = neg_reg ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});
    assign mprod   = sine_s * $signed({1'b0, mod_depth});
    assign pos_next = PF'({widx_reg, 16'd0}) - PF'({base_delay, 8'd0})
                    + PF'(mod_reg) - PF'(ONE_SAMPLE);
    assign rd_sel  = cmd.ch ? rdr_q : rdl_q;
    assign dry_sel = cmd.ch ? rin_reg : lin_reg;
    assign diff    = {rd_sel[SW-1], rd_sel} - {a_reg[SW-1], a_reg};
    assign m_sat   = (wet_mix > WET_FULL) ? WET_FULL : wet_mix;
    assign sum     = (SW+19)'(p1_reg) + (SW+19)'(p2_reg) + (SW+19)'($signed({1'b0, ROUND_HALF}));
    assign mixv    = (SW+3)'(sum >>> 16);
    assign mix_sat = (mixv > SAT_HI) ? SW'(SAT_HI) : (mixv < SAT_LO) ? SW'(SAT_LO) : SW'(mixv);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            lin_reg <= left_in;
            rin_reg <= right_in;
        end
        if (cmd.rom_en)
        begin
            rom_q   <= sine_tab[rom_addr];
            neg_reg <= sidx[SB-1];
        end
        if (cmd.mod_en)
            mod_reg <= 27'(mprod >>> 8);
        if (cmd.pos_en)
            pos_reg <= pos_next;
        if (cmd.rdb_en)
            a_reg <= rd_sel;
        if (cmd.int1_en)
            prod_reg <= diff * $signed({1'b0, pos_reg[15:0]});
        if (cmd.int2_en)
            wet_reg <= a_reg + SW'(prod_reg >>> 16);
        if (cmd.mix1_en)
            p1_reg <= dry_sel * $signed({1'b0, WET_FULL - m_sat});
        if (cmd.mix2_en)
            p2_reg <= wet_reg * $signed({1'b0, m_sat});
        if (cmd.mix3_en)
        begin
            if (cmd.ch)
                rres_reg <= mix_sat;
            else
                lres_reg <= mix_sat;
        end
        if (cmd.out_load)
        begin
            lout_reg <= lres_reg;
            rout_reg <= rres_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            widx_reg      <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_en)
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (cmd.commit)
            begin
                widx_reg  <= widx_reg + AW'(1);
                phase_reg <= phase_reg + lfo_step;
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign sts.clr_last = (clr_cnt_reg == {AW{1'b1}});
    assign sts.out_free = !out_valid_reg || !out_stall;
    assign out_valid    = out_valid_reg;
    assign left_out     = lout_reg;
    assign right_out    = rout_reg;

endmodule

@@ test/tb_stereo_chorus_delay_unit.sv @@
// Testbench for the stereo chorus delay unit: directed and random frames against a local predictor.
`timescale 1ns / 1ps
module tb_stereo_chorus_delay_unit;
    import scd_pkg::*;

    localparam int DEPTH  = 8192;
    localparam int SBITS  = 24;
    localparam int QLEN   = 256;     // quarter of the 1024-entry sine cycle
    localparam int SETTLE = 40;      // idle wait at the end of drain, in clock cycles

    typedef struct {
        logic signed [SBITS-1:0] left;
        logic signed [SBITS-1:0] right;
    } frame_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic signed [SBITS-1:0] left_in;
    logic signed [SBITS-1:0] right_in;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [SBITS-1:0] left_out;
    logic signed [SBITS-1:0] right_out;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [3:0]              paddr;
    logic [31:0]             pwdata;
    logic [31:0]             prdata;
    logic                    pready;

    stereo_chorus_delay_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .left_in  (left_in),
        .right_in (right_in),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .left_out (left_out),
        .right_out(right_out),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ---------------------------------------------------------------
    // Predictor state: own copy of the delay lines, LFO and registers
    // ---------------------------------------------------------------
    int          quarter_wave [QLEN+1];
    int          left_hist    [DEPTH];
    int          right_hist   [DEPTH];
    int          wr_pos;
    logic [31:0] lfo_acc;
    logic [31:0] cur_step;
    logic [16:0] cur_depth;
    logic [19:0] cur_delay;
    logic [16:0] cur_wet;

    frame_t expected_frames[$];
    int     errors;
    int     send_idle_pct;       // chance per cycle the sender holds off
    int     stall_pct;           // chance per cycle the receiver stalls
    int     stall_hold;          // forced stall cycles left, counted in receiver

    // Q30 product truncated toward zero
    function automatic longint q30_product(input longint a, input longint b);
        longint p;
        p = a * b;
        if (p >= 0)
            return p >>> 30;
        return -((-p) >>> 30);
    endfunction

    function automatic void build_quarter_wave();
        longint x;
        longint x2;
        longint acc;
        longint v;
        for (int k = 0; k <= QLEN; k++)
        begin
            x   = (longint'(k) <<< 30) / QLEN;
            x2  = q30_product(x, x);
            acc = 172272;
            acc = -5026995 + q30_product(acc, x2);
            acc = 85569306 + q30_product(acc, x2);
            acc = -693598668 + q30_product(acc, x2);
            acc = 1686629713 + q30_product(acc, x2);
            acc = q30_product(acc, x);
            v   = (acc + 8192) >>> 14;
            if (v < 0)
                v = 0;
            if (v > 65536)
                v = 65536;
            quarter_wave[k] = int'(v);
        end
    endfunction

    // full-wave sine in Q16 from quadrant symmetry, no interpolation
    function automatic longint lfo_sine(input logic [31:0] phase);
        logic [1:0] quad;
        int         r;
        quad = phase[31:30];
        r    = int'(phase[29:22]);
        case (quad)
            2'd0:    return quarter_wave[r];
            2'd1:    return quarter_wave[QLEN - r];
            2'd2:    return -longint'(quarter_wave[r]);
            default: return -longint'(quarter_wave[QLEN - r]);
        endcase
    endfunction

    // interpolated read of one line at the modulated tap
    function automatic longint tap_read(input bit right_ch, input logic [31:0] phase);
        longint span;
        longint md;
        longint pos;
        longint i0;
        longint i1;
        longint fr;
        longint a;
        longint b;
        span = longint'(DEPTH) * 65536;
        md   = (lfo_sine(phase) * longint'(cur_depth)) >>> 8;
        pos  = longint'(wr_pos) * 65536 - longint'(cur_delay) * 256 + md - 65536;
        pos  = pos % span;
        if (pos < 0)
            pos += span;
        i0 = pos >>> 16;
        i1 = (i0 + 1) % DEPTH;
        fr = pos & 16'hFFFF;
        a  = right_ch ? right_hist[i0] : left_hist[i0];
        b  = right_ch ? right_hist[i1] : left_hist[i1];
        return a + (((b - a) * fr) >>> 16);
    endfunction

    function automatic logic signed [SBITS-1:0] dry_wet(input longint dry, input longint wet);
        longint m;
        longint v;
        m = (cur_wet > WET_FULL) ? 65536 : longint'(cur_wet);
        v = (dry * (65536 - m) + wet * m + 32768) >>> 16;
        if (v > 8388607)
            v = 8388607;
        if (v < -8388608)
            v = -8388608;
        return v[SBITS-1:0];
    endfunction

    // one accepted frame: store input, read both taps, mix, advance
    function automatic void predict_frame(input logic signed [SBITS-1:0] l,
                                          input logic signed [SBITS-1:0] r);
        frame_t f;
        longint lw;
        longint rw;
        left_hist[wr_pos]  = l;
        right_hist[wr_pos] = r;
        lw      = tap_read(1'b0, lfo_acc);
        rw      = tap_read(1'b1, lfo_acc + QUARTER_PHASE);
        f.left  = dry_wet(l, lw);
        f.right = dry_wet(r, rw);
        expected_frames.push_back(f);
        wr_pos  = (wr_pos + 1) % DEPTH;
        lfo_acc = lfo_acc + cur_step;
    endfunction

    // ---------------------------------------------------------------
    // Clock, reset, timeout
    // ---------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #40ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ---------------------------------------------------------------
    // Receiver: random stalls plus an optional long forced hold-off
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (stall_hold > 0)
        begin
            stall_hold <= stall_hold - 1;
            out_stall  <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Result checker: decide acceptance at the falling edge, where all
    // inputs and outputs are settled, and count it at the next rising edge.
    always
    begin
        logic   take;
        frame_t got;
        frame_t exp_f;
        @(negedge clk);
        take      = rst_n && out_valid && !out_stall;
        got.left  = left_out;
        got.right = right_out;
        @(posedge clk);
        if (take)
        begin
            if (expected_frames.size() == 0)
            begin
                $error("result with nothing expected: left_out %0d right_out %0d",
                       got.left, got.right);
                errors++;
            end
            else
            begin
                exp_f = expected_frames.pop_front();
                if (got.left !== exp_f.left)
                begin
                    $error("left_out expected %0d actual %0d", exp_f.left, got.left);
                    errors++;
                end
                if (got.right !== exp_f.right)
                begin
                    $error("right_out expected %0d actual %0d", exp_f.right, got.right);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Shared tasks
    // ---------------------------------------------------------------
    // Called at a rising edge; returns at the edge where the item was taken.
    // Valid stays high afterward so back-to-back items need no extra step.
    task automatic send_frame(input logic signed [SBITS-1:0] l,
                              input logic signed [SBITS-1:0] r);
        logic taken;
        in_valid <= 1'b1;
        left_in  <= l;
        right_in <= r;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        predict_frame(l, r);
    endtask

    // drop valid and idle at random after an item
    task automatic sender_gap();
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_frame(SBITS'($urandom), SBITS'($urandom));
            sender_gap();
        end
    endtask

    // wait for every expected result, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // APB write: setup then access; raw data so bits above a width get dropped
    task automatic reg_write(input reg_idx_t idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_LFO_STEP:   cur_step  = data;
            REG_MOD_DEPTH:  cur_depth = data[16:0];
            REG_BASE_DELAY: cur_delay = data[19:0];
            default:        cur_wet   = data[16:0];
        endcase
    endtask

    task automatic set_all(input logic [31:0] step, input logic [31:0] depth,
                           input logic [31:0] dly, input logic [31:0] wet);
        reg_write(REG_LFO_STEP, step);
        reg_write(REG_MOD_DEPTH, depth);
        reg_write(REG_BASE_DELAY, dly);
        reg_write(REG_WET_MIX, wet);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // reset values of the registers, field extremes on both channels
    task automatic test_reset_defaults();
        send_idle_pct = 0;
        stall_pct     = 0;
        send_frame(24'sh7FFFFF, -24'sh800000);
        send_frame(-24'sh800000, 24'sh7FFFFF);
        send_frame(24'sh000000, -24'sh000001);
        send_frame(24'sh555555, 24'shAAAAAA);
        send_frame(24'shAAAAAA, 24'sh555555);
        drain();
    endtask

    // wet share at none, full and above full (saturates)
    task automatic test_mix_extremes();
        set_all(32'h0100_0000, 32'd25600, 32'd512, 32'd0);
        send_frame(24'sh7FFFFF, -24'sh800000);
        send_frame(24'sh123456, -24'sh123456);
        drain();
        reg_write(REG_WET_MIX, 32'd65536);
        send_frame(-24'sh800000, 24'sh7FFFFF);
        send_frame(24'sh7FFFFF, 24'sh7FFFFF);
        drain();
        // upper bits set: value beyond the width, low 17 bits above full
        reg_write(REG_WET_MIX, 32'hFFFF_FFFF);
        send_frame(24'sh400000, -24'sh400000);
        send_frame(-24'sh7FFFFF, 24'sh7FFFFF);
        drain();
    endtask

    // zero delay reads the previous frame; deep delay and full depth wrap
    task automatic test_delay_wrap();
        set_all(32'd0, 32'd0, 32'd0, 32'd65536);
        send_frame(24'sh7FFFFF, -24'sh800000);
        send_frame(24'sh100000, 24'sh200000);
        drain();
        set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd40000);
        send_frame(-24'sh800000, -24'sh800000);
        send_frame(24'sh7FFFFF, 24'sh7FFFFF);
        send_frame(24'sh0ABCDE, -24'sh0ABCDE);
        drain();
        set_all(32'h4000_0000, 32'd131071, 32'd0, 32'd65536);
        send_frame(24'sh333333, -24'sh333333);
        send_frame(-24'sh222222, 24'sh222222);
        send_frame(24'sh7FFFFF, -24'sh800000);
        send_frame(24'sh010101, 24'sh020202);
        drain();
    endtask

    // random frames under one idling profile and fresh random registers
    task automatic test_random(input int count, input int idle_pct, input int stall);
        logic [31:0] wet;
        wet = ($urandom_range(7) == 0) ? $urandom : $urandom_range(65536);
        set_all($urandom, $urandom, $urandom, wet);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        send_random(count);
        drain();
    endtask

    // long receiver hold-off while the sender keeps offering items
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        stall_hold    = 400;
        send_random(30);
        drain();
    endtask

    // sender pauses midway until every result is in, then goes on
    task automatic test_sender_pause();
        send_idle_pct = 20;
        stall_pct     = 30;
        send_random(20);
        in_valid <= 1'b0;
        while (expected_frames.size() != 0)
            @(posedge clk);
        @(posedge clk);
        send_random(20);
        drain();
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        left_in       = '0;
        right_in      = '0;
        out_stall     = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        errors        = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        stall_hold    = 0;
        wr_pos        = 0;
        lfo_acc       = '0;
        cur_step      = LFO_STEP_RST;
        cur_depth     = MOD_DEPTH_RST;
        cur_delay     = BASE_DELAY_RST;
        cur_wet       = WET_MIX_RST;
        for (int i = 0; i < DEPTH; i++)
        begin
            left_hist[i]  = 0;
            right_hist[i] = 0;
        end
        build_quarter_wave();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // the block clears its lines first; send_frame waits on in_stall
        test_reset_defaults();
        test_mix_extremes();
        test_delay_wrap();
        test_random(200, 0, 0);
        test_random(200, 48, 0);
        test_random(200, 0, 48);
        test_random(200, 37, 37);
        test_backpressure();
        test_sender_pause();

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
